### hdl/itsbf_pkg.sv
// Shared types for the IPv4 TCP source blocklist filter.
package itsbf_pkg;

   typedef enum logic [1:0] {
      REQ_PKT   = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_READ  = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      RSN_SHORT_ETH = 3'd0,
      RSN_NOT_IPV4  = 3'd1,
      RSN_SHORT_IP  = 3'd2,
      RSN_NOT_TCP   = 3'd3,
      RSN_NO_MATCH  = 3'd4,
      RSN_BLOCKED   = 3'd5
   } reason_type;

   typedef enum logic [1:0] {
      CMD_VERDICT = 2'd0,
      CMD_LOOKUP  = 2'd1,
      CMD_WRITE   = 2'd2,
      CMD_READ    = 2'd3
   } cmd_kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_IDLE  = 2'd1,
      ST_READ  = 2'd2,
      ST_SCAN  = 2'd3
   } back_state_type;

   typedef enum logic {
      RSP_VERDICT = 1'b0,
      RSP_ENTRY   = 1'b1
   } rsp_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      reason_type   reason;
      logic [5:0]   index;
      logic [31:0]  key;
      logic         valid;
      logic [31:0]  count;
   } cmd_type;

   typedef struct packed {
      rsp_kind_type kind;
      logic         verdict;
      reason_type   reason;
      logic [5:0]   index;
      logic [31:0]  key;
      logic         valid;
      logic [31:0]  count;
   } rsp_type;

endpackage

### hdl/itsbf_front.sv
// Front end: tracks frame bytes, captures header fields, classifies each frame and forwards table requests.
module itsbf_front import itsbf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_pkt_byte,
   input  logic        req_pkt_last,
   input  logic [5:0]  req_entry_index,
   input  logic [31:0] req_entry_key,
   input  logic        req_entry_valid,
   input  logic [31:0] req_entry_count,
   output logic        cmd_push,
   output cmd_type     cmd_word
);

   localparam logic [5:0]  POS_ETH_HI   = 6'd12;
   localparam logic [5:0]  POS_ETH_LO   = 6'd13;
   localparam logic [5:0]  POS_PROTO    = 6'd23;
   localparam logic [5:0]  POS_SRC_FIRST = 6'd26;
   localparam logic [5:0]  POS_SRC_LAST = 6'd29;
   localparam logic [5:0]  POS_IP_LAST  = 6'd33;
   localparam logic [5:0]  POS_MAX      = 6'd63;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP    = 8'd6;

   logic [5:0]  byte_position_ff, byte_position_in;
   logic [15:0] ether_type_ff, ether_type_in;
   logic [7:0]  ip_protocol_ff, ip_protocol_in;
   logic [31:0] source_address_ff, source_address_in;
   logic [15:0] eth_cap;
   logic [7:0]  proto_cap;
   logic [31:0] src_cap;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff  <= '0;
         ether_type_ff     <= '0;
         ip_protocol_ff    <= '0;
         source_address_ff <= '0;
      end else begin
         byte_position_ff  <= byte_position_in;
         ether_type_ff     <= ether_type_in;
         ip_protocol_ff    <= ip_protocol_in;
         source_address_ff <= source_address_in;
      end
   end

   always_comb begin
      eth_cap   = ether_type_ff;
      proto_cap = ip_protocol_ff;
      src_cap   = source_address_ff;
      if (byte_position_ff == POS_ETH_HI || byte_position_ff == POS_ETH_LO) begin
         eth_cap = {ether_type_ff[7:0], req_pkt_byte};
      end else if (byte_position_ff == POS_PROTO) begin
         proto_cap = req_pkt_byte;
      end else if (byte_position_ff >= POS_SRC_FIRST && byte_position_ff <= POS_SRC_LAST) begin
         src_cap = {source_address_ff[23:0], req_pkt_byte};
      end
   end

   always_comb begin
      byte_position_in  = byte_position_ff;
      ether_type_in     = ether_type_ff;
      ip_protocol_in    = ip_protocol_ff;
      source_address_in = source_address_ff;
      cmd_push          = 1'b0;
      cmd_word.kind     = CMD_WRITE;
      cmd_word.reason   = RSN_SHORT_ETH;
      cmd_word.index    = req_entry_index;
      cmd_word.key      = req_entry_key;
      cmd_word.valid    = req_entry_valid;
      cmd_word.count    = req_entry_count;
      if (accept) begin
         unique case (req_type)
            REQ_PKT: begin
               if (req_pkt_last) begin
                  cmd_push          = 1'b1;
                  cmd_word.kind     = CMD_VERDICT;
                  cmd_word.key      = src_cap;
                  byte_position_in  = '0;
                  ether_type_in     = '0;
                  ip_protocol_in    = '0;
                  source_address_in = '0;
                  if (byte_position_ff < POS_ETH_LO) begin
                     cmd_word.reason = RSN_SHORT_ETH;
                  end else if (eth_cap != ETHERTYPE_IPV4) begin
                     cmd_word.reason = RSN_NOT_IPV4;
                  end else if (byte_position_ff < POS_IP_LAST) begin
                     cmd_word.reason = RSN_SHORT_IP;
                  end else if (proto_cap != PROTO_TCP) begin
                     cmd_word.reason = RSN_NOT_TCP;
                  end else begin
                     cmd_word.kind   = CMD_LOOKUP;
                     cmd_word.reason = RSN_NO_MATCH;
                  end
               end else begin
                  ether_type_in     = eth_cap;
                  ip_protocol_in    = proto_cap;
                  source_address_in = src_cap;
                  byte_position_in  = (byte_position_ff == POS_MAX) ? POS_MAX :
                                      byte_position_ff + 6'd1;
               end
            end
            REQ_WRITE: begin
               cmd_push      = 1'b1;
               cmd_word.kind = CMD_WRITE;
            end
            REQ_READ: begin
               cmd_push      = 1'b1;
               cmd_word.kind = CMD_READ;
            end
            default: begin
               cmd_push = 1'b0;
            end
         endcase
      end
   end

endmodule

### hdl/itsbf_cmd_fifo.sv
// Short command queue between the front end and the table engine.
module itsbf_cmd_fifo import itsbf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_word,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_word,
   output logic    empty
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     fill_ff, fill_in;
   logic               do_push, do_pop;

   assign full     = (fill_ff == (PTR_W+1)'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_word = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

### hdl/itsbf_back.sv
// Table engine: blocklist memory, clearing pass, lookup scan and result register.
module itsbf_back import itsbf_pkg::*; #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_ready,
   input  cmd_type cmd_word,
   output logic    cmd_take,
   output logic    clearing,
   output logic    rsp_valid,
   output rsp_type rsp_word,
   input  logic    rsp_take
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(TABLE_ENTRIES - 1);

   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [31:0] count;
   } entry_type;

   entry_type        mem [TABLE_ENTRIES];
   entry_type        rd_data_ff;
   entry_type        wr_data;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             wr_en;

   back_state_type   state_ff, state_in;
   logic [IDX_W-1:0] chk_ff, chk_in;
   logic [31:0]      key_ff, key_in;
   logic             in_range_ff, in_range_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             in_range;

   function automatic rsp_type make_verdict(reason_type reason, logic [5:0] index);
      rsp_type r;
      r         = '0;
      r.kind    = RSP_VERDICT;
      r.reason  = reason;
      r.index   = index;
      case (reason) inside
         RSN_SHORT_ETH, RSN_SHORT_IP, RSN_BLOCKED: r.verdict = 1'b1;
         default:                                  r.verdict = 1'b0;
      endcase
      return r;
   endfunction

   assign in_range  = (32'(cmd_word.index) < TABLE_ENTRIES);
   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         chk_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      in_range_ff <= in_range_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      chk_in       = chk_ff;
      key_in       = key_ff;
      in_range_in  = in_range_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      cmd_take     = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = chk_ff;
      wr_data      = '0;
      rd_addr      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (chk_ff == LAST_ADDR) begin
               chk_in   = '0;
               state_in = ST_IDLE;
            end else begin
               chk_in = chk_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            if (cmd_ready && !rsp_valid_ff) begin
               cmd_take = 1'b1;
               unique case (cmd_word.kind)
                  CMD_WRITE: begin
                     if (in_range) begin
                        wr_en         = 1'b1;
                        wr_addr       = IDX_W'(cmd_word.index);
                        wr_data.valid = cmd_word.valid;
                        wr_data.key   = cmd_word.key;
                        wr_data.count = cmd_word.count;
                     end
                  end
                  CMD_READ: begin
                     in_range_in = in_range;
                     rd_addr     = in_range ? IDX_W'(cmd_word.index) : '0;
                     state_in    = ST_READ;
                  end
                  CMD_LOOKUP: begin
                     key_in   = cmd_word.key;
                     chk_in   = '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = make_verdict(cmd_word.reason, 6'd0);
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            rsp_in.kind  = RSP_ENTRY;
            if (in_range_ff) begin
               rsp_in.key   = rd_data_ff.key;
               rsp_in.valid = rd_data_ff.valid;
               rsp_in.count = rd_data_ff.count;
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (rd_data_ff.valid && rd_data_ff.key == key_ff) begin
               wr_en         = 1'b1;
               wr_addr       = chk_ff;
               wr_data       = rd_data_ff;
               wr_data.count = (rd_data_ff.count == '1) ? rd_data_ff.count :
                               rd_data_ff.count + 32'd1;
               rsp_valid_in  = 1'b1;
               rsp_in        = make_verdict(RSN_BLOCKED, 6'(chk_ff));
               state_in      = ST_IDLE;
            end else if (chk_ff == LAST_ADDR) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_verdict(RSN_NO_MATCH, 6'd0);
               state_in     = ST_IDLE;
            end else begin
               chk_in  = chk_ff + IDX_W'(1);
               rd_addr = chk_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hdl/ipv4_tcp_source_blocklist_filter_top.sv
// Top level of the IPv4 TCP source blocklist filter.
//
//   Channel   Handshake       Ports
//   request   push / full     req_type, req_pkt_byte, req_pkt_last, req_entry_*
//   response  pop / empty     rsp_resp_kind, rsp_verdict*, rsp_matched_index, rsp_read_*
//
// The front end takes one word per cycle until its four-deep command queue fills.
// A table write completes in the idle state, a read passes through the read state, and
// a lookup scans one entry per cycle through the table memory read port.
// After reset the table is cleared one entry per cycle, with full held high. The engine
// waits while the response register is occupied.
module ipv4_tcp_source_blocklist_filter_top import itsbf_pkg::*; #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_pkt_byte,
   input  logic        req_pkt_last,
   input  logic [5:0]  req_entry_index,
   input  logic [31:0] req_entry_key,
   input  logic        req_entry_valid,
   input  logic [31:0] req_entry_count,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_resp_kind,
   output logic        rsp_verdict,
   output logic [2:0]  rsp_verdict_reason,
   output logic [5:0]  rsp_matched_index,
   output logic [31:0] rsp_read_key,
   output logic        rsp_read_valid,
   output logic [31:0] rsp_read_count
);

   logic    accept;
   logic    cmd_push, q_full, q_empty, cmd_take, clearing, rsp_valid;
   cmd_type push_word, head_word;
   rsp_type rsp_word;

   assign full   = q_full || clearing;
   assign accept = push && !full;
   assign empty  = !rsp_valid;

   itsbf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_type        (req_type),
      .req_pkt_byte    (req_pkt_byte),
      .req_pkt_last    (req_pkt_last),
      .req_entry_index (req_entry_index),
      .req_entry_key   (req_entry_key),
      .req_entry_valid (req_entry_valid),
      .req_entry_count (req_entry_count),
      .cmd_push        (cmd_push),
      .cmd_word        (push_word)
   );

   itsbf_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_word (push_word),
      .full      (q_full),
      .pop       (cmd_take),
      .pop_word  (head_word),
      .empty     (q_empty)
   );

   itsbf_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_ready (!q_empty),
      .cmd_word  (head_word),
      .cmd_take  (cmd_take),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_take  (pop && rsp_valid)
   );

   assign rsp_resp_kind      = rsp_word.kind;
   assign rsp_verdict        = rsp_word.verdict;
   assign rsp_verdict_reason = rsp_word.reason;
   assign rsp_matched_index  = rsp_word.index;
   assign rsp_read_key       = rsp_word.key;
   assign rsp_read_valid     = rsp_word.valid;
   assign rsp_read_count     = rsp_word.count;

endmodule
